FILE: hdl/pctd_pkg.sv
// Package for the prefix-code text decoder: result types and the fixed codeword table.
// Also holds the lookup function. No dependencies.
package pctd_pkg;

    localparam int CODE_COUNT = 29;
    localparam int MIN_LEN    = 4;
    localparam int MAX_LEN    = 9;

    typedef struct packed {
        logic [8:0] code;
        logic [3:0] len;
        logic [6:0] ch;
    } pctd_code_t;

    // One decoded result; error set means nine bits hit no codeword
    typedef struct packed {
        logic [6:0] symbol;
        logic       error;
    } pctd_res_t;

    // Results produced by one byte, in order
    typedef struct packed {
        logic [1:0] n;
        pctd_res_t  res0;
        pctd_res_t  res1;
    } pctd_batch_t;

    // Codes gather first-bit-lowest
    localparam pctd_code_t CODE_TABLE [CODE_COUNT] = '{
        '{9'd7,   4'd4, 7'h61}, '{9'd113, 4'd7, 7'h62}, '{9'd29,  4'd5, 7'h63},
        '{9'd225, 4'd8, 7'h64}, '{9'd9,   4'd4, 7'h65}, '{9'd17,  4'd7, 7'h66},
        '{9'd49,  4'd7, 7'h67}, '{9'd81,  4'd7, 7'h68}, '{9'd3,   4'd4, 7'h69},
        '{9'd31,  4'd6, 7'h6a}, '{9'd24,  4'd5, 7'h6b}, '{9'd65,  4'd7, 7'h6c},
        '{9'd1,   4'd7, 7'h6d}, '{9'd10,  4'd4, 7'h6e}, '{9'd5,   4'd4, 7'h6f},
        '{9'd8,   4'd5, 7'h70}, '{9'd289, 4'd9, 7'h71}, '{9'd2,   4'd4, 7'h72},
        '{9'd27,  4'd5, 7'h73}, '{9'd11,  4'd5, 7'h74}, '{9'd63,  4'd6, 7'h75},
        '{9'd33,  4'd9, 7'h76}, '{9'd15,  4'd5, 7'h77}, '{9'd161, 4'd8, 7'h78},
        '{9'd13,  4'd5, 7'h79}, '{9'd4,   4'd4, 7'h7a}, '{9'd14,  4'd4, 7'h20},
        '{9'd6,   4'd4, 7'h2e}, '{9'd12,  4'd4, 7'h0a}
    };

    // Character for (value, length); zero when nothing matches
    function automatic logic [6:0] pctd_lookup(input logic [8:0] value, input logic [3:0] len);
        logic [6:0] ch;
        ch = '0;
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (CODE_TABLE[i].len == len && CODE_TABLE[i].code == value) begin
                ch = CODE_TABLE[i].ch;
            end
        end
        return ch;
    endfunction

endpackage

FILE: hdl/pctd_unpack.sv
// Bit unpacker: pending-codeword state plus eight unrolled bit steps per byte.
// Depends on pctd_pkg.
module pctd_unpack (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [7:0]         code_byte,
    output pctd_pkg::pctd_batch_t batch
);
    import pctd_pkg::*;

    logic [7:0] bits_reg, bits_next;
    logic [3:0] cnt_reg, cnt_next;

    logic [8:0] val;
    logic [3:0] cnt_inc;
    logic [6:0] ch;
    logic [1:0] n;

    always_comb begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        n         = '0;
        val       = '0;
        cnt_inc   = '0;
        ch        = '0;
        batch     = '0;
        for (int b = 7; b >= 0; b--) begin
            val     = {1'b0, bits_next} | (9'(code_byte[b]) << cnt_next);
            cnt_inc = cnt_next + 4'd1;
            ch      = (cnt_inc >= 4'(MIN_LEN)) ? pctd_lookup(val, cnt_inc) : '0;
            if (ch != '0 || cnt_inc >= 4'(MAX_LEN)) begin
                if (n == 2'd0) begin
                    batch.res0 = '{symbol: ch, error: (ch == '0)};
                end else if (n == 2'd1) begin
                    batch.res1 = '{symbol: ch, error: (ch == '0)};
                end
                if (n != 2'd2) begin
                    n = n + 2'd1;
                end
                bits_next = '0;
                cnt_next  = '0;
            end else begin
                bits_next = val[7:0];
                cnt_next  = cnt_inc;
            end
        end
        batch.n = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
            cnt_reg  <= '0;
        end else if (advance) begin
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: hdl/pctd_out_buf.sv
// Two-entry result buffer feeding the m_ channel; takes a whole batch when it has room.
// Depends on pctd_pkg.
module pctd_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  pctd_pkg::pctd_batch_t batch,
    output logic                  space,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [6:0]            m_symbol,
    output logic                  m_error,
    output logic                  m_last
);
    import pctd_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    pctd_res_t  e0_reg, e0_next;
    pctd_res_t  e1_reg, e1_next;
    logic       e0_last_reg, e0_last_next;
    logic       pop;

    assign pop   = (cnt_reg != 2'd0) && m_ready;
    // room for a full batch once the buffer drains this cycle
    assign space = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        cnt_next     = cnt_reg;
        e0_next      = e0_reg;
        e1_next      = e1_reg;
        e0_last_next = e0_last_reg;
        if (load) begin
            cnt_next     = batch.n;
            e0_next      = batch.res0;
            e1_next      = batch.res1;
            e0_last_next = (batch.n == 2'd1);
        end else if (pop) begin
            cnt_next     = cnt_reg - 2'd1;
            e0_next      = e1_reg;
            e0_last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg      <= e0_next;
        e1_reg      <= e1_next;
        e0_last_reg <= e0_last_next;
    end

    assign m_valid  = (cnt_reg != 2'd0);
    assign m_symbol = e0_reg.symbol;
    assign m_error  = e0_reg.error;
    assign m_last   = e0_last_reg;

endmodule

FILE: hdl/prefix_code_text_decoder.sv
// Top level of the prefix-code text decoder: input register, unpacker, result buffer.
// Depends on pctd_pkg, pctd_unpack, pctd_out_buf.
//
// Usage:
//   s_ channel carries one packed code word per beat (s_coded_byte), first
//   code bit in bit 7. m_ channel returns decoded characters one per beat:
//   m_symbol (ASCII), m_error (nine bits with no codeword, symbol zero) and
//   m_last (final result caused by that input word). A word that completes no
//   codeword yields no result; its bits stay pending for the next word.
//   A word goes from the input register into the result buffer before its first result shows.
//   Throughput: one word per cycle when it yields zero or one result and m_ready
//   is high; a word that yields two results fills the two-entry result buffer and
//   holds back the next word, since the m_ port drains one result per cycle.
//   The input register can take a word while results wait in the buffer;
//   when m_ready stays low the buffer fills, then the input register, and
//   s_ready drops. Nothing is lost or reordered under stalls.
//   Reset (aresetn low, synchronous) empties both stages and clears the
//   pending codeword bits.
module prefix_code_text_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_coded_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_symbol,
    output logic       m_error,
    output logic       m_last
);
    import pctd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        space;
    logic        advance;
    pctd_batch_t batch;

    // word leaves the input register when the buffer can take all its results
    assign advance = in_valid_reg && space;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_coded_byte;
        end
    end

    pctd_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .code_byte (in_byte_reg),
        .batch     (batch)
    );

    pctd_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .batch    (batch),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_symbol (m_symbol),
        .m_error  (m_error),
        .m_last   (m_last)
    );

    // error results carry a zero symbol
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_symbol == 7'd0)
        else $error("error result with nonzero symbol");

    // a good result always carries a character
    a_sym_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error |-> m_symbol != 7'd0)
        else $error("decoded result with zero symbol");

    // empty input register always takes a word
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

FILE: sim/prefix_code_text_decoder_test.sv
// Self-checking bench for prefix_code_text_decoder: packed code words in, ASCII results out.
// Builds its own bit-level decoder and codebook to predict results; needs only the RTL.
// Covers directed corner words, then mostly valid encoded text with noise and bad codewords.
module prefix_code_text_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS   = 1650;  // random part stops once this many are queued
    localparam int TAIL_WORDS     = 150;   // last words go out with no idling on either side
    localparam int IDLE_LIMIT     = 2000;  // cycles with no handshake before giving up
    localparam int HOLDOFF_AT     = 300;   // results seen before the long receiver stall
    localparam int HOLDOFF_CYCLES = 250;
    localparam int DRAIN_AT       = 1000;  // words accepted before the sender waits for drain
    localparam int SETTLE_CYCLES  = 20;
    localparam int REPORT_MAX     = 10;
    localparam int NUM_CODES      = 29;
    localparam int SHORTEST_CODE  = 4;
    localparam int LONGEST_CODE   = 9;

    typedef struct packed {
        logic [8:0] code;
        logic [3:0] len;
        logic [6:0] ch;
    } codeword_t;

    typedef struct packed {
        logic [6:0] symbol;
        logic       error;
        logic       last;
    } char_result_t;

    logic       aclk;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_coded_byte = 8'h00;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [6:0] m_symbol;
    logic       m_error;
    logic       m_last;

    prefix_code_text_decoder DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coded_byte (s_coded_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_symbol     (m_symbol),
        .m_error      (m_error),
        .m_last       (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Codebook: code value is stored first-bit-lowest, so bit k of .code is the k-th bit sent
    function automatic codeword_t codeword_at(input int idx);
        case (idx)
            0:  return {9'd7,   4'd4, 7'h61};
            1:  return {9'd113, 4'd7, 7'h62};
            2:  return {9'd29,  4'd5, 7'h63};
            3:  return {9'd225, 4'd8, 7'h64};
            4:  return {9'd9,   4'd4, 7'h65};
            5:  return {9'd17,  4'd7, 7'h66};
            6:  return {9'd49,  4'd7, 7'h67};
            7:  return {9'd81,  4'd7, 7'h68};
            8:  return {9'd3,   4'd4, 7'h69};
            9:  return {9'd31,  4'd6, 7'h6a};
            10: return {9'd24,  4'd5, 7'h6b};
            11: return {9'd65,  4'd7, 7'h6c};
            12: return {9'd1,   4'd7, 7'h6d};
            13: return {9'd10,  4'd4, 7'h6e};
            14: return {9'd5,   4'd4, 7'h6f};
            15: return {9'd8,   4'd5, 7'h70};
            16: return {9'd289, 4'd9, 7'h71};
            17: return {9'd2,   4'd4, 7'h72};
            18: return {9'd27,  4'd5, 7'h73};
            19: return {9'd11,  4'd5, 7'h74};
            20: return {9'd63,  4'd6, 7'h75};
            21: return {9'd33,  4'd9, 7'h76};
            22: return {9'd15,  4'd5, 7'h77};
            23: return {9'd161, 4'd8, 7'h78};
            24: return {9'd13,  4'd5, 7'h79};
            25: return {9'd4,   4'd4, 7'h7a};
            26: return {9'd14,  4'd4, 7'h20};
            27: return {9'd6,   4'd4, 7'h2e};
            default: return {9'd12, 4'd4, 7'h0a};
        endcase
    endfunction

    // Zero means no codeword of that length has that value
    function automatic logic [6:0] char_for_code(input logic [8:0] value, input logic [3:0] len);
        codeword_t cw;
        logic [6:0] ch;
        ch = 7'd0;
        for (int i = 0; i < NUM_CODES; i++) begin
            cw = codeword_at(i);
            if (cw.len == len && cw.code == value) begin
                ch = cw.ch;
            end
        end
        return ch;
    endfunction

    // Decoder state mirrored on the bench side
    logic [7:0] partial_bits  = 8'd0;
    logic [3:0] partial_count = 4'd0;

    char_result_t chars_due[$];      // results still owed by the DUT, oldest first
    logic [7:0]   words_to_send[$];  // stimulus not yet offered
    bit           stream_bits[$];    // encoder scratch, first bit sent at the front

    // Walk one word MSB first and queue every character or error it completes
    task automatic decode_word(input logic [7:0] word);
        logic [8:0]   val;
        logic [3:0]   cnt;
        logic [6:0]   ch;
        char_result_t found[2];
        int           n;
        n = 0;
        for (int b = 7; b >= 0; b--) begin
            cnt = (partial_count > 4'd8) ? 4'd8 : partial_count;
            val = {1'b0, partial_bits} | ({8'd0, word[b]} << cnt);
            cnt = cnt + 4'd1;
            ch  = (cnt >= SHORTEST_CODE) ? char_for_code(val, cnt) : 7'd0;
            if (ch != 7'd0 || cnt >= LONGEST_CODE) begin
                if (n < 2) begin
                    found[n].symbol = ch;
                    found[n].error  = (ch == 7'd0);
                    found[n].last   = 1'b0;
                    n++;
                end
                partial_bits  = 8'd0;
                partial_count = 4'd0;
            end else begin
                partial_bits  = val[7:0];
                partial_count = cnt;
            end
        end
        if (n > 0) begin
            found[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            chars_due.push_back(found[i]);
        end
    endtask

    task automatic push_char(input int idx);
        codeword_t cw;
        cw = codeword_at(idx);
        for (int k = 0; k < cw.len; k++) begin
            stream_bits.push_back(cw.code[k]);
        end
    endtask

    // Move whole words out of the bit stream; pad_out flushes a partial word with zeros
    task automatic pack_words(input bit pad_out);
        logic [7:0] w;
        if (pad_out) begin
            while (stream_bits.size() % 8 != 0) begin
                stream_bits.push_back(1'b0);
            end
        end
        while (stream_bits.size() >= 8) begin
            for (int b = 7; b >= 0; b--) begin
                w[b] = stream_bits.pop_front();
            end
            words_to_send.push_back(w);
        end
    endtask

    //------------------------------------------------------------------
    // Sender: offers queued words, holds them under backpressure,
    // idles in random bursts, and pauses once for a full drain.
    //------------------------------------------------------------------
    int unsigned words_accepted = 0;
    int unsigned sender_gap     = 0;
    bit          drain_done     = 1'b0;
    bit          quiet_tail     = 1'b0;

    always @(posedge aclk) begin
        logic offer_now;
        logic calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_word(s_coded_byte);
                words_accepted++;
            end
            // Held word stays on the bus untouched until taken
            if (!(s_valid && !s_ready)) begin
                offer_now = 1'b1;
                if (words_to_send.size() <= TAIL_WORDS) begin
                    quiet_tail = 1'b1;
                end
                calm = quiet_tail || ((words_accepted / 200) % 4 == 3);
                // One-time pause: nothing new until every owed result is back
                if (!drain_done && words_accepted >= DRAIN_AT) begin
                    if (chars_due.size() != 0) begin
                        offer_now = 1'b0;
                    end else begin
                        drain_done = 1'b1;
                    end
                end
                if (sender_gap != 0) begin
                    sender_gap--;
                    offer_now = 1'b0;
                end else if (offer_now && !calm && $urandom_range(0, 9) == 0) begin
                    sender_gap = $urandom_range(1, 17) - 1;
                    offer_now  = 1'b0;
                end
                if (offer_now && words_to_send.size() != 0) begin
                    s_valid      <= 1'b1;
                    s_coded_byte <= words_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Receiver: checks each result against the oldest owed one,
    // drops ready in random bursts and once for a long stretch.
    //------------------------------------------------------------------
    int unsigned chars_seen     = 0;
    int unsigned mismatch_count = 0;
    int unsigned receiver_gap   = 0;
    int unsigned holdoff_left   = 0;
    bit          holdoff_done   = 1'b0;

    always @(posedge aclk) begin
        char_result_t want;
        logic         ready_next;
        logic         calm;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                chars_seen++;
                if (chars_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("%0t: result with none owed: symbol %h error %b last %b",
                                 $realtime, m_symbol, m_error, m_last);
                    end
                end else begin
                    want = chars_due.pop_front();
                    if (want.symbol !== m_symbol || want.error !== m_error ||
                        want.last !== m_last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: result %0d: symbol %h/%h error %b/%b last %b/%b (exp/act)",
                                     $realtime, chars_seen, want.symbol, m_symbol,
                                     want.error, m_error, want.last, m_last);
                        end
                    end
                end
            end
            ready_next = 1'b1;
            calm = quiet_tail || ((chars_seen / 300) % 4 == 1);
            // Long stall so the result buffer and input stage both fill
            if (!holdoff_done && chars_seen >= HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                ready_next = 1'b0;
            end else if (receiver_gap != 0) begin
                receiver_gap--;
                ready_next = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                receiver_gap = $urandom_range(1, 17) - 1;
                ready_next   = 1'b0;
            end
            m_ready <= ready_next;
        end
    end

    // Watchdog: too long without any handshake on either side
    int unsigned idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus and end of run
    //------------------------------------------------------------------
    initial begin
        int directed_words;
        int pick;

        // From reset: eight zeros stay pending with no result, the ninth zero
        // falls in unused code space and errors, and an all-ones word gives
        // a second error at nine bits followed by a 'u' (two results)
        words_to_send.push_back(8'h00);
        words_to_send.push_back(8'h00);
        words_to_send.push_back(8'hFF);
        // Every character once; the zero pad leaves trailing bits pending
        for (int i = 0; i < NUM_CODES; i++) begin
            push_char(i);
        end
        pack_words(1'b1);
        directed_words = words_to_send.size();

        // Mostly valid text, some codewords from unused space, some raw noise
        while (words_to_send.size() - directed_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                repeat ($urandom_range(1, 30)) begin
                    push_char($urandom_range(0, NUM_CODES - 1));
                end
            end else if (pick < 90) begin
                // 0000 prefix: an error once nine bits are in, if it starts on a codeword boundary
                repeat (4) stream_bits.push_back(1'b0);
                repeat (5) stream_bits.push_back($urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(1, 16)) stream_bits.push_back($urandom_range(0, 1));
            end
            pack_words(1'b0);
        end
        pack_words(1'b1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_to_send.size() != 0 || s_valid || chars_due.size() != 0) begin
            @(posedge aclk);
        end
        // Let any stray extra result show up
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && chars_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/pctd_pkg.sv
hdl/pctd_unpack.sv
hdl/pctd_out_buf.sv
hdl/prefix_code_text_decoder.sv
sim/prefix_code_text_decoder_test.sv
